>>> hw/rtl/htmg_pkg.sv
// Package for the heading tape marker generator: widths, marker kinds,
// controller command and status structures, and degree folding.
// No dependencies.
package htmg_pkg;

	localparam int unsigned DEG_W  = 9;
	localparam int unsigned PIX_W  = 10;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned ADDR_W = 3;

	// Marker kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BUG   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRACK = 2'd2;

	// Source of the degree that goes into the position register
	localparam logic [1:0] SRC_TICK  = 2'd0;
	localparam logic [1:0] SRC_BUG   = 2'd1;
	localparam logic [1:0] SRC_TRACK = 2'd2;

	// Register indexes (paddr[2])
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	localparam logic [PIX_W-1:0] WIDTH_RESET  = 10'd320;
	localparam logic [PIX_W-1:0] OFFSET_RESET = 10'd160;

	localparam logic [5:0] MAX_TICKS = 6'd52;

	typedef struct packed {
		logic              capture;
		logic              calc_window;
		logic              calc_quot;
		logic              calc_start;
		logic              calc_fold;
		logic              load_x;
		logic [1:0]        x_src;
		logic              step;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_last;
	} htmg_cmd_t;

	typedef struct packed {
		logic tick_ok;
	} htmg_stat_t;

	// Fold a 9-bit degree into 0..359
	function automatic logic [DEG_W-1:0] fold9(input logic [DEG_W-1:0] v);
		logic [DEG_W-1:0] r;
		r = (v >= 9'd360) ? (v - 9'd360) : v;
		return r;
	endfunction

endpackage

>>> hw/rtl/htmg_ctrl.sv
// Controller of the heading tape marker generator: frame sequencer and
// output valid. Depends on htmg_pkg.
module htmg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  htmg_pkg::htmg_stat_t stat,
	output htmg_pkg::htmg_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WIN   = 4'd1;
	localparam logic [3:0] ST_QUOT  = 4'd2;
	localparam logic [3:0] ST_START = 4'd3;
	localparam logic [3:0] ST_FOLD  = 4'd4;
	localparam logic [3:0] ST_XT    = 4'd5;
	localparam logic [3:0] ST_TICK  = 4'd6;
	localparam logic [3:0] ST_BPREP = 4'd7;
	localparam logic [3:0] ST_BUG   = 4'd8;
	localparam logic [3:0] ST_TPREP = 4'd9;
	localparam logic [3:0] ST_TRK   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	// Output slot can take a new marker when empty or being taken this cycle
	assign out_free  = !out_valid_q || !out_stall;

	// Sequencer
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_WIN;
				end
			end
			ST_WIN: begin
				cmd.calc_window = 1'b1;
				state_nxt       = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.calc_quot = 1'b1;
				state_nxt     = ST_START;
			end
			ST_START: begin
				cmd.calc_start = 1'b1;
				state_nxt      = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.calc_fold = 1'b1;
				state_nxt     = ST_XT;
			end
			ST_XT: begin
				cmd.load_x = 1'b1;
				cmd.x_src  = htmg_pkg::SRC_TICK;
				state_nxt  = ST_TICK;
			end
			ST_TICK: begin
				if (!stat.tick_ok) begin
					state_nxt = ST_BPREP;
				end else if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = htmg_pkg::KIND_TICK;
					cmd.step      = 1'b1;
				end
			end
			ST_BPREP: begin
				cmd.load_x = 1'b1;
				cmd.x_src  = htmg_pkg::SRC_BUG;
				state_nxt  = ST_BUG;
			end
			ST_BUG: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = htmg_pkg::KIND_BUG;
					state_nxt     = ST_TPREP;
				end
			end
			ST_TPREP: begin
				cmd.load_x = 1'b1;
				cmd.x_src  = htmg_pkg::SRC_TRACK;
				state_nxt  = ST_TRK;
			end
			ST_TRK: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = htmg_pkg::KIND_TRACK;
					cmd.emit_last = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.emit | (out_valid_q & out_stall);
		end
	end

endmodule

>>> hw/rtl/htmg_dpath.sv
// Datapath of the heading tape marker generator: window set-up, tick
// stepping, position clamp and output register. Depends on htmg_pkg.
module htmg_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [htmg_pkg::PIX_W-1:0]            display_width,
	input  logic [htmg_pkg::PIX_W-1:0]            center_offset,
	input  logic [htmg_pkg::DEG_W-1:0]            heading_deg,
	input  logic [htmg_pkg::DEG_W-1:0]            bug_deg,
	input  logic [htmg_pkg::DEG_W-1:0]            track_deg,
	input  htmg_pkg::htmg_cmd_t                    cmd,
	output htmg_pkg::htmg_stat_t                   stat,
	output logic [htmg_pkg::KIND_W-1:0]           marker_kind,
	output logic [htmg_pkg::PIX_W-1:0]            x_pos,
	output logic                                  major_tick,
	output logic [htmg_pkg::DEG_W-1:0]            label_deg,
	output logic                                  last_marker
);

	// Frame operands
	logic [8:0]  head_q, bugf_q, trkf_q;
	// Window
	logic        neg_q;
	logic [8:0]  mag_q;
	logic [10:0] right_q;
	logic [6:0]  k_q;
	// Tick walker
	logic [10:0] d_q;
	logic [8:0]  fold_q;
	logic        major_q;
	logic [5:0]  n_q;
	logic [12:0] xr_q;
	// Output register
	logic [1:0]  kind_q;
	logic [9:0]  x_q;
	logic        major_out_q;
	logic [8:0]  label_q;
	logic        last_q;

	logic [10:0] left_w, right_w;
	logic [8:0]  mag_w;
	logic [16:0] prod_w;
	logic [6:0]  quot_w;
	logic [9:0]  rem_w;
	logic [9:0]  mr_w;
	logic [8:0]  src_w;
	logic [12:0] diff_w;
	logic [12:0] wx_w;
	logic [12:0] xa_w;
	logic [9:0]  xc_w;
	logic        wrap_w;

	// Window edges in degrees
	always_comb begin
		left_w  = {2'b00, head_q} - {3'b000, center_offset[9:2]};
		right_w = {2'b00, head_q} + {3'b000, display_width[9:2]}
			- {3'b000, center_offset[9:2]};
		mag_w   = left_w[10] ? 9'(-left_w) : left_w[8:0];
	end

	// Divide magnitude by five: reciprocal multiply, exact below 1024
	always_comb begin
		prod_w = 17'(mag_q) * 17'd205;
		quot_w = prod_w[16:10];
		rem_w  = {1'b0, mag_q} - (10'(quot_w) * 10'd5);
		mr_w   = 10'(k_q) * 10'd5;
	end

	// Position source and raw position
	always_comb begin
		case (cmd.x_src)
			htmg_pkg::SRC_TICK:  src_w = fold_q;
			htmg_pkg::SRC_BUG:   src_w = bugf_q;
			htmg_pkg::SRC_TRACK: src_w = trkf_q;
			default:             src_w = fold_q;
		endcase
		diff_w = {4'b0000, src_w} - {4'b0000, head_q};
	end

	// Clamp: subtract a full turn past the right edge, then saturate
	always_comb begin
		wx_w = {3'b000, display_width};
		xa_w = ($signed(xr_q) > $signed(wx_w)) ? (xr_q - 13'd1440) : xr_q;
		if (xa_w[12]) begin
			xc_w = '0;
		end else if ($signed(xa_w) > $signed(wx_w)) begin
			xc_w = (display_width == '0) ? '0 : (display_width - 10'd1);
		end else begin
			xc_w = xa_w[9:0];
		end
	end

	assign wrap_w       = (fold_q >= 9'd355);
	assign stat.tick_ok = ($signed(d_q) <= $signed(right_q)) && (n_q < htmg_pkg::MAX_TICKS);

	// Set-up and walker registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			head_q <= heading_deg;
			bugf_q <= htmg_pkg::fold9(bug_deg);
			trkf_q <= htmg_pkg::fold9(track_deg);
		end
		if (cmd.calc_window) begin
			neg_q   <= left_w[10];
			mag_q   <= mag_w;
			right_q <= right_w;
		end
		if (cmd.calc_quot) begin
			k_q <= quot_w + {6'd0, (rem_w != '0)};
		end
		if (cmd.calc_start) begin
			d_q     <= neg_q ? 11'(-{1'b0, mr_w}) : {1'b0, mr_w};
			major_q <= ~k_q[0];
			n_q     <= '0;
		end
		if (cmd.calc_fold) begin
			if (d_q[10]) begin
				fold_q <= 9'(d_q + 11'd360);
			end else if ($signed(d_q) >= $signed(11'd360)) begin
				fold_q <= 9'(d_q - 11'd360);
			end else begin
				fold_q <= d_q[8:0];
			end
		end
		if (cmd.load_x) begin
			xr_q <= {diff_w[10:0], 2'b00} + {3'b000, center_offset};
		end else if (cmd.step) begin
			// Next tick: five degrees on, twenty pixels on, folded past 359
			if (wrap_w) begin
				fold_q <= fold_q - 9'd355;
				xr_q   <= xr_q - 13'd1420;
			end else begin
				fold_q <= fold_q + 9'd5;
				xr_q   <= xr_q + 13'd20;
			end
		end
		if (cmd.step) begin
			d_q     <= d_q + 11'd5;
			n_q     <= n_q + 6'd1;
			major_q <= ~major_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= htmg_pkg::KIND_TICK;
			last_q      <= 1'b0;
			major_out_q <= 1'b0;
		end else if (cmd.emit) begin
			kind_q      <= cmd.emit_kind;
			last_q      <= cmd.emit_last;
			major_out_q <= (cmd.emit_kind == htmg_pkg::KIND_TICK) ? major_q : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			x_q     <= xc_w;
			label_q <= (cmd.emit_kind == htmg_pkg::KIND_TICK) ? fold_q : '0;
		end
	end

	assign marker_kind = kind_q;
	assign x_pos       = x_q;
	assign major_tick  = major_out_q;
	assign label_deg   = label_q;
	assign last_marker = last_q;

endmodule

>>> hw/rtl/heading_tape_marker_generator.sv
// Top level of the heading tape marker generator: configuration registers,
// controller and datapath. Depends on htmg_pkg, htmg_ctrl and htmg_dpath.
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  heading_deg, bug_deg, track_deg
//  out      out        out_valid/out_stall  marker_kind, x_pos, major_tick,
//                                           label_deg, last_marker
//  cfg      in         APB write/read       display_width (0x0), center_offset (0x4)
//
// A frame runs the set-up states (capture, window, quotient, start, fold, tick
// position load), then emits the scale ticks (at most 52), and prepares and
// emits the heading bug marker and then the track marker.
// One frame is worked on at a time; in_stall is high from acceptance until
// the track marker is loaded into the output register.
// Reset (arst_n low) sets width 320 and offset 160 and empties the output.
// A stalled output holds the sequencer until the marker is taken.
module heading_tape_marker_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [htmg_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [htmg_pkg::DEG_W-1:0]         heading_deg,
	input  logic [htmg_pkg::DEG_W-1:0]         bug_deg,
	input  logic [htmg_pkg::DEG_W-1:0]         track_deg,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [htmg_pkg::KIND_W-1:0]        marker_kind,
	output logic [htmg_pkg::PIX_W-1:0]         x_pos,
	output logic                               major_tick,
	output logic [htmg_pkg::DEG_W-1:0]         label_deg,
	output logic                               last_marker
);

	logic [htmg_pkg::PIX_W-1:0] width_q;
	logic [htmg_pkg::PIX_W-1:0] offset_q;
	logic                       wr_en;
	htmg_pkg::htmg_cmd_t         cmd;
	htmg_pkg::htmg_stat_t        stat;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= htmg_pkg::WIDTH_RESET;
			offset_q <= htmg_pkg::OFFSET_RESET;
		end else if (wr_en) begin
			if (paddr[2] == htmg_pkg::REG_WIDTH) begin
				width_q <= pwdata[htmg_pkg::PIX_W-1:0];
			end else begin
				offset_q <= pwdata[htmg_pkg::PIX_W-1:0];
			end
		end
	end

	// Read-back
	assign prdata = (paddr[2] == htmg_pkg::REG_WIDTH) ? {22'd0, width_q} : {22'd0, offset_q};

	htmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	htmg_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.display_width (width_q),
		.center_offset (offset_q),
		.heading_deg   (heading_deg),
		.bug_deg       (bug_deg),
		.track_deg     (track_deg),
		.cmd           (cmd),
		.stat          (stat),
		.marker_kind   (marker_kind),
		.x_pos         (x_pos),
		.major_tick    (major_tick),
		.label_deg     (label_deg),
		.last_marker   (last_marker)
	);

`ifndef SYNTHESIS
	// One frame at a time: an accepted request closes the input
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a frame is in progress");

	// The frame closes on the track marker
	a_last_is_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_marker) |-> (marker_kind == htmg_pkg::KIND_TRACK))
		else $error("last marker is not the track marker");

	// Bug and track markers carry no label and no major flag
	a_bug_no_label: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && marker_kind != htmg_pkg::KIND_TICK) |->
		(label_deg == '0 && !major_tick))
		else $error("bug or track marker carries tick fields");
`endif

endmodule
